/* rtl/fdm_pkg.sv */
package fdm_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned NumSteps = DataWidth / BitsPerStage;

  typedef enum logic {
    CMD_DIV = 1'b0,
    CMD_MOD = 1'b1
  } cmd_t;

  // per-item control carried down the pipe
  typedef struct packed {
    logic cmd;
    logic m_neg;
    logic differ;
    logic zero_div;
    logic minus_one;
  } ctrl_t;

endpackage

/* rtl/floored_div_mod_unit_core.sv */
// Floored signed divide / modulo unit, 64-bit.
//
// Input channel s_axis: tdata carries the dividend (bits 63:0) and the divisor
// (bits 127:64); tuser carries the command (0 floor divide, 1 floor modulo).
// Output channel m_axis: tdata carries the result; tuser carries the
// divide-by-zero flag. A zero divisor gives result 0 with the flag set; a
// divisor of minus one gives the wrapping negation (divide) or 0 (modulo).
//
// One word is accepted per cycle while the receiver keeps m_axis_tready high.
// The pipe holds one register for operand magnitudes, one restoring divide
// stage per two quotient bits, and one register for the sign fixup.
// The restoring subtract chain of each stage sets the clock period.
//
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls (m_axis_tready low) the full stages hold while
// empty stages still fill, and s_axis_tready drops only if the output word is
// waiting and a bubble-free pipe cannot advance; nothing is lost or repeated.
module floored_div_mod_unit_core #(
  parameter int unsigned DataWidth = fdm_pkg::DataWidth,
  parameter int unsigned BitsPerStage = fdm_pkg::BitsPerStage
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*DataWidth-1:0] s_axis_tdata,  // dividend, divisor
  input  logic                   s_axis_tuser,  // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DataWidth-1:0]   m_axis_tdata,  // result
  output logic                   m_axis_tuser   // divide_by_zero
);

  localparam int unsigned Steps = DataWidth / BitsPerStage;
  localparam int unsigned Depth = Steps + 2;

  logic [Depth-1:0] vld;
  logic [Depth-1:0] adv;

  // stall logic: a stage advances when the one after it is empty or advancing
  always_comb begin
    adv[Depth-1] = !vld[Depth-1] || m_axis_tready;
    for (int i = Depth - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  // stage 0: magnitudes and special-case detect
  logic [DataWidth-1:0] m_in, n_in;
  assign m_in = s_axis_tdata[DataWidth-1:0];
  assign n_in = s_axis_tdata[2*DataWidth-1:DataWidth];

  logic [DataWidth-1:0] q0, r0, d0, n0;
  fdm_pkg::ctrl_t c0;
  logic vld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_in <= 1'b0;
    end else if (adv[0]) begin
      vld_in <= s_axis_tvalid;
    end
    if (adv[0]) begin
      q0 <= m_in[DataWidth-1] ? -m_in : m_in;
      d0 <= n_in[DataWidth-1] ? -n_in : n_in;
      n0 <= n_in;
      r0 <= '0;
      c0.cmd <= s_axis_tuser;
      c0.m_neg <= m_in[DataWidth-1];
      c0.differ <= m_in[DataWidth-1] ^ n_in[DataWidth-1];
      c0.zero_div <= (n_in == '0);
      c0.minus_one <= (n_in == '1);
    end
  end

  assign vld[0] = vld_in;

  // divide stages: quotient bits shift into q while dividend bits shift out
  logic [DataWidth-1:0] qs [Steps+1];
  logic [DataWidth-1:0] rs [Steps+1];
  logic [DataWidth-1:0] ds [Steps+1];
  logic [DataWidth-1:0] ns [Steps+1];
  fdm_pkg::ctrl_t       cs [Steps+1];

  assign qs[0] = q0;
  assign rs[0] = r0;
  assign ds[0] = d0;
  assign ns[0] = n0;
  assign cs[0] = c0;

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [DataWidth-1:0] q_next, r_next;

    // restoring steps, one quotient bit each
    always_comb begin
      logic [DataWidth:0] trial;
      q_next = qs[s];
      r_next = rs[s];
      for (int b = 0; b < BitsPerStage; b++) begin
        trial = {r_next, q_next[DataWidth-1]} - {1'b0, ds[s]};
        q_next = {q_next[DataWidth-2:0], !trial[DataWidth]};
        if (!trial[DataWidth]) begin
          r_next = trial[DataWidth-1:0];
        end else begin
          r_next = {r_next[DataWidth-2:0], qs[s][DataWidth-1-b]};
        end
      end
    end

    logic [DataWidth-1:0] q_r, r_r, d_r, n_r;
    fdm_pkg::ctrl_t c_r;
    logic v_r;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (adv[s+1]) begin
        v_r <= vld[s];
      end
      if (adv[s+1]) begin
        q_r <= q_next;
        r_r <= r_next;
        d_r <= ds[s];
        n_r <= ns[s];
        c_r <= cs[s];
      end
    end

    assign vld[s+1] = v_r;
    assign qs[s+1] = q_r;
    assign rs[s+1] = r_r;
    assign ds[s+1] = d_r;
    assign ns[s+1] = n_r;
    assign cs[s+1] = c_r;
  end

  // final stage: sign fixup and special cases
  logic [DataWidth-1:0] tq, tr, nn, res_next;
  fdm_pkg::ctrl_t cf;
  logic rem_nz;
  logic vld_out;

  assign tq = qs[Steps];
  assign tr = rs[Steps];
  assign nn = ns[Steps];
  assign cf = cs[Steps];
  assign rem_nz = (tr != '0);

  always_comb begin
    if (cf.zero_div || (cf.minus_one && cf.cmd == fdm_pkg::CMD_MOD)) begin
      res_next = '0;
    end else if (cf.cmd == fdm_pkg::CMD_DIV) begin
      // minus-one divisor also lands here and gives -m: |m|, negated when m is positive
      res_next = cf.differ ? (~tq + {{(DataWidth-1){1'b0}}, !rem_nz}) : tq;
    end else begin
      res_next = (cf.m_neg ? -tr : tr) + ((cf.differ && rem_nz) ? nn : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv[Depth-1]) begin
      vld_out <= vld[Depth-2];
    end
    if (adv[Depth-1]) begin
      m_axis_tdata <= res_next;
      m_axis_tuser <= cf.zero_div;
    end
  end

  assign vld[Depth-1] = vld_out;
  assign m_axis_tvalid = vld[Depth-1];

endmodule
